// File: rtl/bitmode_vram_write_protect_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the engine RTL; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef BITMODE_VRAM_WRITE_PROTECT_ENGINE_ASSERT_SVH
`define BITMODE_VRAM_WRITE_PROTECT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define VWPE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vwpe assertion failed");
// checked on every edge, reset included
`define VWPE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("vwpe assertion failed");
`else
`define VWPE_ASSERT(lbl, clk, rst_n, prop)
`define VWPE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/vwpe_pkg.sv
// ----------------------------------------------------------------------------
// vwpe_pkg
// Types, constants and the protect table index function.
// ----------------------------------------------------------------------------
package vwpe_pkg;

  localparam int BANK_DEPTH_DEF = 16384;
  localparam int TBL_DEPTH      = 256;
  localparam int TBL_IDX_W      = 8;
  localparam int NIB_W          = 4;
  localparam int NUM_NIB        = 4;
  localparam int REQ_W          = 3;
  localparam int ADDR_W         = 16;
  localparam int DATA_W         = 8;
  localparam int CTL_N          = 8;
  localparam int CTL_IDX_W      = 3;

  localparam logic [ADDR_W-1:0] PAGE_MASK = 16'hf000;
  localparam logic [ADDR_W-1:0] PAGE_BMP  = 16'h4000;
  localparam logic [ADDR_W-1:0] ROW_MASK  = 16'h3800;
  localparam logic [ADDR_W-1:0] COL_MASK  = 16'h0600;
  localparam logic [DATA_W-1:0] RD_FILL   = 8'hf0;

  // control latch roles
  localparam int CTL_X_HOLD = 0;
  localparam int CTL_Y_HOLD = 1;
  localparam int CTL_IDX6   = 4;
  localparam int CTL_IDX5   = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_DIRECT_WR = 3'd0,
    REQ_BM_READ   = 3'd1,
    REQ_BM_WRITE  = 3'd2,
    REQ_LATCH_WR  = 3'd3,
    REQ_CTL_WR    = 3'd4,
    REQ_TBL_LOAD  = 3'd5
  } req_t;

  function automatic logic [TBL_IDX_W-1:0] tbl_index(
    input logic              bitmd,
    input logic              ctl_a,
    input logic              ctl_b,
    input logic [ADDR_W-1:0] addr,
    input logic [1:0]        pix
  );
    tbl_index = {bitmd, ctl_a, ctl_b,
                 (addr & PAGE_MASK) != PAGE_BMP,
                 (addr & ROW_MASK) == '0,
                 (addr & COL_MASK) == COL_MASK,
                 pix};
  endfunction

endpackage

// File: rtl/bitmode_vram_write_protect_engine.sv
// ----------------------------------------------------------------------------
// bitmode_vram_write_protect_engine
// Two-bank 4-bit pixel video RAM access unit with write-protect table.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while in_ready is high. Each word is
// registered into the table and video RAM address ports on acceptance; in the
// following cycle the protect table entry gates the four nibble write enables
// of the video RAM. A bit-mode read result passes from the RAM read register
// and second stage into the output register; while a read result is held
// there unaccepted, one further read may wait in the second stage and input
// stalls behind it. After reset the video RAM is cleared one row per cycle
// over all BANK_DEPTH rows (16384 by default); in_ready stays low until done.
`include "bitmode_vram_write_protect_engine_assert.svh"

module bitmode_vram_write_protect_engine #(
  parameter int BANK_DEPTH = vwpe_pkg::BANK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vwpe_pkg::REQ_W-1:0]    in_req_type,
  input  logic [vwpe_pkg::ADDR_W-1:0]   in_addr,
  input  logic [vwpe_pkg::DATA_W-1:0]   in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vwpe_pkg::DATA_W-1:0]   out_read_data
);

  import vwpe_pkg::*;

  localparam int OFS_W = $clog2(BANK_DEPTH);

  // latches
  logic [7:0]       bm_x_r, bm_x_nxt;
  logic [7:0]       bm_y_r, bm_y_nxt;
  logic [CTL_N-1:0] ctl_r, ctl_nxt;

  // clearing pass
  logic             clr_busy_r;
  logic [OFS_W-1:0] clr_cnt_r;

  // second stage
  logic              s1_wr_r, s1_wr_nxt;
  logic              s1_rd_r, s1_rd_nxt;
  logic [OFS_W-1:0]  s1_waddr_r;
  logic [DATA_W-1:0] s1_wdata_r;
  logic [1:0]        s1_sel_r;
  logic              s1_fwd_r;
  logic [NIB_W-1:0]  s1_fwd_nib_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_read_data_r, out_read_data_nxt;

  logic              accept;
  logic              s1_adv;
  logic              is_wr;
  logic              is_rd;
  logic              is_bm;
  logic [ADDR_W-1:0] bm_addr;
  logic [ADDR_W-1:0] eff_addr;
  logic [DATA_W-1:0] eff_data;
  logic [1:0]        pix;
  logic [TBL_IDX_W-1:0] tbl_idx;
  logic [NIB_W-1:0]  tbl_q;
  logic              fwd_hit;
  logic [NIB_W-1:0]  fwd_nib;
  logic [NIB_W-1:0]  ram_q [NUM_NIB];
  logic [NIB_W-1:0]  rd_nib;

  assign s1_adv   = !(s1_rd_r && out_valid_r && !out_ready);
  assign in_ready = !clr_busy_r && s1_adv;
  assign accept   = in_valid && in_ready;

  assign is_bm = (in_req_type == REQ_BM_WRITE);
  assign is_rd = (in_req_type == REQ_BM_READ);
  assign is_wr = (in_req_type == REQ_DIRECT_WR) || is_bm || (in_req_type == REQ_LATCH_WR);

  assign bm_addr  = {2'b00, bm_y_r, bm_x_r[7:2]};
  assign eff_addr = is_bm ? bm_addr : in_addr;
  assign eff_data = is_bm ? {in_data[3:0], in_data[3:0]} : in_data;
  assign pix      = is_bm ? bm_x_r[1:0] : 2'b00;
  assign tbl_idx  = tbl_index(is_bm, ctl_r[CTL_IDX6], ctl_r[CTL_IDX5], eff_addr, pix);

  // protect table, loaded by request; entries undefined until loaded
  vwpe_ram #(
    .WIDTH(NIB_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl (
    .clk  (clk),
    .we   (accept && (in_req_type == REQ_TBL_LOAD)),
    .waddr(in_addr[TBL_IDX_W-1:0]),
    .wdata(in_data[NIB_W-1:0]),
    .re   (accept && is_wr),
    .raddr(tbl_idx),
    .rdata(tbl_q)
  );

  // Nibble RAM k: k[1] low selects bank 1, k[0] low selects the high nibble.
  // Table bit k is the active-low enable of RAM k.
  for (genvar k = 0; k < NUM_NIB; k++) begin : g_nib
    logic             we;
    logic [OFS_W-1:0] waddr;
    logic [NIB_W-1:0] wdata;

    assign we    = clr_busy_r || (s1_wr_r && !tbl_q[k]);
    assign waddr = clr_busy_r ? clr_cnt_r : s1_waddr_r;
    assign wdata = clr_busy_r ? '0 :
                   (k % 2 == 1) ? s1_wdata_r[NIB_W-1:0] : s1_wdata_r[DATA_W-1:NIB_W];

    vwpe_ram #(
      .WIDTH(NIB_W),
      .DEPTH(BANK_DEPTH)
    ) u_vram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (accept && is_rd),
      .raddr(bm_addr[OFS_W-1:0]),
      .rdata(ram_q[k])
    );
  end

  // write retiring this edge hits the read being issued
  assign fwd_hit = s1_wr_r && (s1_waddr_r == bm_addr[OFS_W-1:0]) && !tbl_q[bm_x_r[1:0]];
  assign fwd_nib = bm_x_r[0] ? s1_wdata_r[NIB_W-1:0] : s1_wdata_r[DATA_W-1:NIB_W];
  assign rd_nib  = s1_fwd_r ? s1_fwd_nib_r : ram_q[s1_sel_r];

  always_comb begin
    bm_x_nxt = bm_x_r;
    bm_y_nxt = bm_y_r;
    ctl_nxt  = ctl_r;
    if (accept) begin
      case (in_req_type)
        REQ_BM_READ, REQ_BM_WRITE: begin
          if (!ctl_r[CTL_X_HOLD]) bm_x_nxt = bm_x_r + 8'd1;
          if (!ctl_r[CTL_Y_HOLD]) bm_y_nxt = bm_y_r + 8'd1;
        end
        REQ_LATCH_WR: begin
          if (in_addr[0]) bm_y_nxt = in_data;
          else            bm_x_nxt = in_data;
        end
        REQ_CTL_WR: begin
          ctl_nxt[in_addr[CTL_IDX_W-1:0]] = in_data[DATA_W-1];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_wr_nxt = s1_wr_r;
    s1_rd_nxt = s1_rd_r;
    if (accept) begin
      s1_wr_nxt = is_wr;
      s1_rd_nxt = is_rd;
    end else if (s1_adv) begin
      s1_wr_nxt = 1'b0;
      s1_rd_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt     = out_valid_r;
    out_read_data_nxt = out_read_data_r;
    if (s1_rd_r && s1_adv) begin
      out_valid_nxt     = 1'b1;
      out_read_data_nxt = RD_FILL | {{(DATA_W-NIB_W){1'b0}}, rd_nib};
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_x_r      <= '0;
      bm_y_r      <= '0;
      ctl_r       <= '0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_wr_r     <= 1'b0;
      s1_rd_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bm_x_r      <= bm_x_nxt;
      bm_y_r      <= bm_y_nxt;
      ctl_r       <= ctl_nxt;
      s1_wr_r     <= s1_wr_nxt;
      s1_rd_r     <= s1_rd_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + OFS_W'(1);
        if (clr_cnt_r == OFS_W'(BANK_DEPTH - 1)) clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_read_data_r <= out_read_data_nxt;
    if (accept) begin
      s1_waddr_r   <= eff_addr[OFS_W-1:0];
      s1_wdata_r   <= eff_data;
      s1_sel_r     <= bm_x_r[1:0];
      s1_fwd_r     <= fwd_hit;
      s1_fwd_nib_r <= fwd_nib;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

  `VWPE_ASSERT(a_clr_quiet, clk, rst_n, clr_busy_r |-> (!s1_wr_r && !s1_rd_r && !out_valid_r))
  `VWPE_ASSERT(a_stall_rd_only, clk, rst_n, (!s1_adv) |-> (s1_rd_r && !s1_wr_r))
  `VWPE_ASSERT(a_rd_to_out, clk, rst_n, (s1_rd_r && s1_adv) |=> out_valid_r)
  `VWPE_ASSERT(a_stall_hold, clk, rst_n, (!s1_adv) |=> (s1_rd_r && $stable(s1_sel_r)))
  `VWPE_ASSERT_ALWAYS(a_rst_idle, clk, (!rst_n) |=> (!s1_wr_r && !s1_rd_r && !out_valid_r))

endmodule

// File: rtl/vwpe_ram.sv
// ----------------------------------------------------------------------------
// vwpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vwpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
